// ===== sv/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked list engine package
// Shared defaults, operation codes and transaction payload types.
// ----------------------------------------------------------------------------
package alle_pkg;

  // Defaults for the top level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_INS_AT    = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;
  localparam logic [2:0] OP_INS_ORD   = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  // Request transaction
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [4:0]  position;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic        ok;
    logic [31:0] removed_value;
    logic [4:0]  count;
  } rsp_t;

endpackage

// ===== sv/alle_store.sv =====
// ----------------------------------------------------------------------------
// Linked list slot store
// Value and link memories with one shared read address, registered read
// data and one write port each.
// ----------------------------------------------------------------------------
module alle_store #(
  parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF,
  parameter int SW         = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic [SW-1:0]         rd_addr,
  input  logic                  val_we,
  input  logic [SW-1:0]         val_waddr,
  input  logic [DATA_WIDTH-1:0] val_wdata,
  input  logic                  lnk_we,
  input  logic [SW-1:0]         lnk_waddr,
  input  logic [SW-1:0]         lnk_wdata,
  output logic [DATA_WIDTH-1:0] val_q,
  output logic [SW-1:0]         lnk_q
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_WIDTH-1:0] values [CAPACITY];
  logic [SW-1:0]         links  [CAPACITY];

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      values[val_waddr[AW-1:0]] <= val_wdata;
    end
    val_q <= values[rd_addr[AW-1:0]];
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      links[lnk_waddr[AW-1:0]] <= lnk_wdata;
    end
    lnk_q <= links[rd_addr[AW-1:0]];
  end

endmodule

// ===== sv/array_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// Array linked list engine
// Singly linked list of fixed capacity kept in slot memories, with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   req (req_valid/req_ready) carries op, value and position. One request is
//   worked on at a time; req_ready is high only while the sequencer is idle.
//   rsp (rsp_valid/rsp_ready) returns ok, removed_value and the element count
//   after the request. The response sits in an output register, so the next
//   request is taken while it waits for the receiver.
//   Positional, ordered and back removals walk the list one link per cycle
//   through the single memory read port.
//   Unused slots are handed out from a recycled chain first, then from a fill
//   counter, so reset and clear need no clearing pass over the memories.
//   Reset (rst, synchronous) empties the list. When the receiver stalls, the
//   finished response holds and the sequencer waits before loading the next.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
  parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  alle_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output alle_pkg::rsp_t rsp
);

  localparam int SW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] NONE = SW'(CAPACITY);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ALLOC  = 4'd2;
  localparam logic [3:0] S_LINK2  = 4'd3;
  localparam logic [3:0] S_RF     = 4'd4;
  localparam logic [3:0] S_RB     = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_RMID   = 4'd7;
  localparam logic [3:0] S_GIVE   = 4'd8;
  localparam logic [3:0] S_ORD_H  = 4'd9;
  localparam logic [3:0] S_ORD_T  = 4'd10;
  localparam logic [3:0] S_OWALK  = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;

  // Operation modes
  localparam logic [2:0] M_FRONT = 3'd0;
  localparam logic [2:0] M_BACK  = 3'd1;
  localparam logic [2:0] M_MID   = 3'd2;
  localparam logic [2:0] M_RMID  = 3'd3;
  localparam logic [2:0] M_RBACK = 3'd4;

  logic [3:0]            state, state_next;
  logic [2:0]            mode, mode_next;
  logic [2:0]            op_r, op_r_next;
  logic [DATA_WIDTH-1:0] v_r, v_r_next;
  logic [4:0]            p_r, p_r_next;
  logic [SW-1:0]         head, head_next;
  logic [SW-1:0]         tail, tail_next;
  logic [SW-1:0]         free_head, free_head_next;
  logic [SW-1:0]         fresh, fresh_next;
  logic [SW-1:0]         cnt, cnt_next;
  logic [SW-1:0]         cur, cur_next;
  logic [SW-1:0]         nxt, nxt_next;
  logic [SW-1:0]         newslot, newslot_next;
  logic [SW-1:0]         k, k_next;
  logic [SW-1:0]         tgt, tgt_next;
  logic [DATA_WIDTH-1:0] rv, rv_next;
  logic                  ok_r, ok_r_next;

  logic [SW-1:0]         rd_addr;
  logic                  val_we;
  logic [SW-1:0]         val_waddr;
  logic [DATA_WIDTH-1:0] val_wdata;
  logic                  lnk_we;
  logic [SW-1:0]         lnk_waddr;
  logic [SW-1:0]         lnk_wdata;
  logic [DATA_WIDTH-1:0] val_q;
  logic [SW-1:0]         lnk_q;
  logic                  load_rsp;

  alle_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .SW         (SW)
  ) u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .lnk_we    (lnk_we),
    .lnk_waddr (lnk_waddr),
    .lnk_wdata (lnk_wdata),
    .val_q     (val_q),
    .lnk_q     (lnk_q)
  );

  assign req_ready = (state == S_IDLE);
  assign load_rsp  = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  // Sequencer
  always_comb begin
    logic          full;
    logic          empty;
    logic          stop;
    logic [SW-1:0] slot;
    full  = (cnt == NONE);
    empty = (cnt == '0);
    stop  = 1'b0;
    slot  = '0;

    state_next     = state;
    mode_next      = mode;
    op_r_next      = op_r;
    v_r_next       = v_r;
    p_r_next       = p_r;
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    fresh_next     = fresh;
    cnt_next       = cnt;
    cur_next       = cur;
    nxt_next       = nxt;
    newslot_next   = newslot;
    k_next         = k;
    tgt_next       = tgt;
    rv_next        = rv;
    ok_r_next      = ok_r;
    rd_addr        = head;
    val_we         = 1'b0;
    val_waddr      = newslot;
    val_wdata      = v_r;
    lnk_we         = 1'b0;
    lnk_waddr      = cur;
    lnk_wdata      = NONE;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_r_next  = req.op;
          v_r_next   = DATA_WIDTH'(req.value);
          p_r_next   = req.position;
          state_next = S_DECODE;
        end
      end

      // Check for failure and pick the path
      S_DECODE: begin
        rv_next    = '0;
        ok_r_next  = 1'b0;
        state_next = S_FINISH;
        cur_next   = head;
        nxt_next   = head;
        k_next     = '0;
        tgt_next   = SW'(p_r) - SW'(1);
        unique case (op_r)
          alle_pkg::OP_INS_FRONT: begin
            if (!full) begin
              mode_next  = M_FRONT;
              rd_addr    = free_head;
              state_next = S_ALLOC;
            end
          end
          alle_pkg::OP_INS_BACK: begin
            if (!full) begin
              mode_next  = M_BACK;
              cur_next   = tail;
              rd_addr    = free_head;
              state_next = S_ALLOC;
            end
          end
          alle_pkg::OP_REM_FRONT: begin
            if (!empty) begin
              state_next = S_RF;
            end
          end
          alle_pkg::OP_REM_BACK: begin
            if (!empty) begin
              rd_addr    = tail;
              state_next = S_RB;
            end
          end
          alle_pkg::OP_INS_AT: begin
            if (!full && !(p_r > cnt)) begin
              if (p_r == '0) begin
                mode_next  = M_FRONT;
                rd_addr    = free_head;
                state_next = S_ALLOC;
              end else if (p_r == cnt) begin
                mode_next  = M_BACK;
                cur_next   = tail;
                rd_addr    = free_head;
                state_next = S_ALLOC;
              end else begin
                mode_next  = M_MID;
                state_next = S_WALK;
              end
            end
          end
          alle_pkg::OP_REM_AT: begin
            if (p_r < cnt) begin
              if (p_r == '0) begin
                state_next = S_RF;
              end else if (p_r == cnt - SW'(1)) begin
                rd_addr    = tail;
                state_next = S_RB;
              end else begin
                mode_next  = M_RMID;
                state_next = S_WALK;
              end
            end
          end
          alle_pkg::OP_INS_ORD: begin
            if (!full) begin
              if (empty) begin
                mode_next  = M_FRONT;
                rd_addr    = free_head;
                state_next = S_ALLOC;
              end else begin
                state_next = S_ORD_H;
              end
            end
          end
          alle_pkg::OP_CLEAR: begin
            head_next      = NONE;
            tail_next      = NONE;
            free_head_next = NONE;
            fresh_next     = '0;
            cnt_next       = '0;
            ok_r_next      = 1'b1;
          end
        endcase
      end

      // Take a slot: recycled chain first, else the fill counter
      S_ALLOC: begin
        if (free_head != NONE) begin
          slot           = free_head;
          free_head_next = lnk_q;
        end else begin
          slot       = fresh;
          fresh_next = fresh + SW'(1);
        end
        newslot_next = slot;
        val_we       = 1'b1;
        val_waddr    = slot;
        lnk_we       = 1'b1;
        lnk_waddr    = slot;
        cnt_next     = cnt + SW'(1);
        ok_r_next    = 1'b1;
        state_next   = S_FINISH;
        unique case (mode)
          M_FRONT: begin
            lnk_wdata = head;
            head_next = slot;
            if (tail == NONE) begin
              tail_next = slot;
            end
          end
          M_BACK: begin
            lnk_wdata = NONE;
            tail_next = slot;
            if (cur == NONE) begin
              head_next = slot;
            end else begin
              state_next = S_LINK2;
            end
          end
          default: begin
            lnk_wdata  = nxt;
            state_next = S_LINK2;
          end
        endcase
      end

      // Hook the new slot in after its predecessor
      S_LINK2: begin
        lnk_we     = 1'b1;
        lnk_waddr  = cur;
        lnk_wdata  = newslot;
        state_next = S_FINISH;
      end

      // Front removal: memory holds the head slot
      S_RF: begin
        rv_next   = val_q;
        head_next = lnk_q;
        if (lnk_q == NONE) begin
          tail_next = NONE;
        end
        state_next = S_GIVE;
      end

      // Back removal: memory holds the tail slot
      S_RB: begin
        rv_next  = val_q;
        nxt_next = tail;
        if (head == tail) begin
          head_next  = NONE;
          tail_next  = NONE;
          state_next = S_GIVE;
        end else begin
          cur_next   = head;
          mode_next  = M_RBACK;
          state_next = S_WALK;
        end
      end

      // Walk one link per cycle; lnk_q is the successor of cur
      S_WALK: begin
        stop = (mode == M_RBACK) ? (lnk_q == tail) : (k == tgt);
        if (stop) begin
          unique case (mode)
            M_MID: begin
              nxt_next   = lnk_q;
              rd_addr    = free_head;
              state_next = S_ALLOC;
            end
            M_RMID: begin
              nxt_next   = lnk_q;
              rd_addr    = lnk_q;
              state_next = S_RMID;
            end
            default: begin
              tail_next  = cur;
              lnk_we     = 1'b1;
              lnk_waddr  = cur;
              lnk_wdata  = NONE;
              state_next = S_GIVE;
            end
          endcase
        end else begin
          cur_next = lnk_q;
          k_next   = k + SW'(1);
          rd_addr  = lnk_q;
        end
      end

      // Unlink a middle slot
      S_RMID: begin
        rv_next    = val_q;
        lnk_we     = 1'b1;
        lnk_waddr  = cur;
        lnk_wdata  = lnk_q;
        state_next = S_GIVE;
      end

      // Return the removed slot to the recycled chain
      S_GIVE: begin
        lnk_we         = 1'b1;
        lnk_waddr      = nxt;
        lnk_wdata      = free_head;
        free_head_next = nxt;
        cnt_next       = cnt - SW'(1);
        ok_r_next      = 1'b1;
        state_next     = S_FINISH;
      end

      // Ordered insert: compare against the head
      S_ORD_H: begin
        if (v_r < val_q) begin
          mode_next  = M_FRONT;
          rd_addr    = free_head;
          state_next = S_ALLOC;
        end else begin
          nxt_next   = lnk_q;
          rd_addr    = tail;
          state_next = S_ORD_T;
        end
      end

      // Ordered insert: compare against the tail
      S_ORD_T: begin
        if (!(v_r < val_q)) begin
          mode_next  = M_BACK;
          cur_next   = tail;
          rd_addr    = free_head;
          state_next = S_ALLOC;
        end else begin
          rd_addr    = nxt;
          state_next = S_OWALK;
        end
      end

      // Ordered walk: memory holds slot nxt, the successor of cur
      S_OWALK: begin
        if (v_r < val_q) begin
          mode_next  = M_MID;
          rd_addr    = free_head;
          state_next = S_ALLOC;
        end else begin
          cur_next = nxt;
          nxt_next = lnk_q;
          rd_addr  = lnk_q;
        end
      end

      S_FINISH: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NONE;
      tail      <= NONE;
      free_head <= NONE;
      fresh     <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      cnt       <= cnt_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    mode    <= mode_next;
    op_r    <= op_r_next;
    v_r     <= v_r_next;
    p_r     <= p_r_next;
    cur     <= cur_next;
    nxt     <= nxt_next;
    newslot <= newslot_next;
    k       <= k_next;
    tgt     <= tgt_next;
    rv      <= rv_next;
    ok_r    <= ok_r_next;
    if (load_rsp) begin
      rsp.ok            <= ok_r;
      rsp.removed_value <= 32'(rv);
      rsp.count         <= 5'(cnt);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= NONE)
    else $error("element count above capacity");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (head == NONE) == (tail == NONE))
    else $error("head and tail disagree on empty list");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((cnt == '0) == (head == NONE)))
    else $error("count and head disagree");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.removed_value == '0)
    else $error("failed transaction carries a removed value");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_DECODE)
    else $error("accepted transaction not decoded");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives random and directed list requests, predicts each response with a
// behavioural list model and checks responses in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP   = 16;
  localparam int LIMIT = 2000;

  // Behavioural list model and response checker
  class list_scoreboard;
    logic [31:0]    elems[$];
    alle_pkg::rsp_t pending[$];
    int             errors;

    function void note_request(alle_pkg::req_t r);
      alle_pkg::rsp_t e;
      int             n;
      e = '0;
      n = elems.size();
      case (r.op)
        alle_pkg::OP_INS_FRONT: if (n < CAP) begin
          elems.push_front(r.value); e.ok = 1;
        end
        alle_pkg::OP_INS_BACK: if (n < CAP) begin
          elems.push_back(r.value); e.ok = 1;
        end
        alle_pkg::OP_REM_FRONT: if (n > 0) begin
          e.removed_value = elems.pop_front(); e.ok = 1;
        end
        alle_pkg::OP_REM_BACK: if (n > 0) begin
          e.removed_value = elems.pop_back(); e.ok = 1;
        end
        alle_pkg::OP_INS_AT: if (r.position <= n && n < CAP) begin
          elems.insert(r.position, r.value); e.ok = 1;
        end
        alle_pkg::OP_REM_AT: if (r.position < n) begin
          e.removed_value = elems[r.position];
          elems.delete(r.position);
          e.ok = 1;
        end
        alle_pkg::OP_INS_ORD: if (n < CAP) begin
          int k;
          k = 0;
          // goes after the last element not greater than the value
          if (n > 0 && r.value >= elems[0]) begin
            if (elems[n-1] <= r.value) k = n;
            else while (k < n && elems[k] <= r.value) k++;
          end
          elems.insert(k, r.value);
          e.ok = 1;
        end
        default: begin
          elems.delete(); e.ok = 1;
        end
      endcase
      e.count = 5'(elems.size());
      pending.push_back(e);
    endfunction

    function void check_response(alle_pkg::rsp_t a);
      alle_pkg::rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", a);
        return;
      end
      e = pending.pop_front();
      if (a.ok !== e.ok || a.removed_value !== e.removed_value || a.count !== e.count) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
  alle_pkg::req_t req = '0;
  alle_pkg::rsp_t rsp;
  list_scoreboard board = new();
  int idle_cycles = 0;
  bit sending = 0;

  array_linked_list_engine DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Response side: random stalls, check on accepted transactions
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
  end
  initial begin
    int w;
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        rsp_ready <= 0;
        repeat (w) @(negedge clk);
      end
      rsp_ready <= 1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready) || rst);
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a falling edge; valid stays high into the next call when no gap
  task automatic send(logic [2:0] op, logic [31:0] v, logic [4:0] p);
    int w;
    w = sending ? $urandom_range(0, 6) : 0;
    if (w > 0) begin
      req_valid <= 0;
      repeat (w) @(negedge clk);
    end
    req_valid <= 1;
    req <= '{op: op, value: v, position: p};
    do @(posedge clk); while (!req_ready);
    board.note_request(req);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int n;
    logic [2:0] op;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty removals, bad positions, fill to full, ordered cases
    send(alle_pkg::OP_REM_FRONT, 0, 0);
    send(alle_pkg::OP_REM_BACK, 0, 0);
    send(alle_pkg::OP_REM_AT, 0, 0);
    send(alle_pkg::OP_INS_AT, 1, 1);
    send(alle_pkg::OP_INS_ORD, 32'h8000_0000, 0);
    send(alle_pkg::OP_INS_ORD, 32'h0, 0);
    send(alle_pkg::OP_INS_ORD, 32'hFFFF_FFFF, 0);
    send(alle_pkg::OP_INS_ORD, 32'h8000_0000, 0);
    send(alle_pkg::OP_INS_AT, 32'h5555_5555, 2);
    send(alle_pkg::OP_INS_AT, 32'hAAAA_AAAA, 5);
    send(alle_pkg::OP_INS_AT, 32'h1234_5678, 0);
    send(alle_pkg::OP_INS_AT, 32'h0F0F_0F0F, 6);
    for (int i = 0; i < 10; i++) send(alle_pkg::OP_INS_BACK, $urandom(), 0);
    send(alle_pkg::OP_INS_FRONT, 1, 0);
    send(alle_pkg::OP_INS_AT, 1, 16);
    send(alle_pkg::OP_INS_ORD, 1, 0);
    send(alle_pkg::OP_REM_AT, 0, 16);
    send(alle_pkg::OP_REM_AT, 0, 15);
    send(alle_pkg::OP_REM_AT, 0, 7);
    send(alle_pkg::OP_REM_BACK, 0, 0);
    send(alle_pkg::OP_REM_AT, 0, 31);
    send(alle_pkg::OP_CLEAR, 0, 0);

    // Random: mostly valid positions, sometimes sorted build-ups
    sending = 1;
    for (int i = 0; i < 900; i++) begin
      n = board.elems.size();
      op = 3'($urandom_range(0, 7));
      if (op == alle_pkg::OP_CLEAR && $urandom_range(0, 7) != 0) op = alle_pkg::OP_INS_ORD;
      if ($urandom_range(0, 9) == 0)
        send(op, rand_value(), 5'($urandom_range(0, 31)));
      else
        send(op, rand_value(), 5'($urandom_range(0, n < 16 ? n + 1 : 16)));
    end
    sending = 0;
    req_valid <= 0;

    // Drain remaining responses
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== array_linked_list_engine.f =====
sv/alle_pkg.sv
sv/alle_store.sv
sv/array_linked_list_engine.sv
bench/testbench.sv
